// ===== sv/json_string_array_parser_macros.svh =====
// Assertion macros shared by the parser modules.
`ifndef JSON_STRING_ARRAY_PARSER_MACROS_SVH
`define JSON_STRING_ARRAY_PARSER_MACROS_SVH

// Checked at every clock edge outside reset.
`define JSAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define JSAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/jsap_pkg.sv =====
// Types, limits and character codes of the string array parser.
package jsap_pkg;

  // Limits of the tag list
  localparam int unsigned MAX_TAGS    = 8;
  localparam int unsigned MAX_TAG_LEN = 16;

  localparam int unsigned TAG_CNT_W  = $clog2(MAX_TAGS + 1);
  localparam int unsigned CHAR_CNT_W = $clog2(MAX_TAG_LEN + 1);

  // Fixed widths of the result fields
  localparam int unsigned TAG_INDEX_W = 3;
  localparam int unsigned CHAR_POS_W  = 4;
  localparam int unsigned TAG_TOTAL_W = 4;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_OUTSIDE,
    PH_INSTR,
    PH_ESC,
    PH_DONE
  } jsap_phase_e;

  // Parser state
  typedef struct packed {
    jsap_phase_e             phase;
    logic [CHAR_CNT_W-1:0]   chars;
    logic [TAG_CNT_W-1:0]    tags;
  } jsap_state_t;

  // One result
  typedef struct packed {
    logic                    is_final;
    logic [7:0]              tag_char;
    logic [TAG_INDEX_W-1:0]  tag_index;
    logic [CHAR_POS_W-1:0]   char_pos;
    logic                    parse_ok;
    logic [TAG_TOTAL_W-1:0]  tag_total;
    logic                    last_of_run;
  } jsap_res_t;

  // Results of one byte, in order, handed to the output queue
  typedef struct packed {
    logic [1:0]              cnt;
    jsap_res_t               res0;
    jsap_res_t               res1;
  } jsap_push_t;

endpackage

// ===== sv/jsap_step.sv =====
// Per-byte parser decision: next state and the results a byte causes.
module jsap_step (
  input  jsap_pkg::jsap_state_t cur_i,
  input  logic [7:0]            ch_i,
  output jsap_pkg::jsap_state_t nxt_o,
  output jsap_pkg::jsap_push_t  push_o
);
  import jsap_pkg::*;

  // Room left in the current tag
  function automatic logic has_room(input logic [CHAR_CNT_W-1:0] chars);
    return chars < CHAR_CNT_W'(MAX_TAG_LEN);
  endfunction

  // Character count after one character, saturating
  function automatic logic [CHAR_CNT_W-1:0] bump(input logic [CHAR_CNT_W-1:0] chars);
    return has_room(chars) ? chars + CHAR_CNT_W'(1) : chars;
  endfunction

  // Tag count after closing a string
  function automatic logic [TAG_CNT_W-1:0] close_tags(input logic [CHAR_CNT_W-1:0] chars,
                                                      input logic [TAG_CNT_W-1:0]  tags);
    return (chars != '0 && tags < TAG_CNT_W'(MAX_TAGS)) ? tags + TAG_CNT_W'(1) : tags;
  endfunction

  logic                  is_nul;
  logic                  is_ws;
  logic                  list_open;
  logic                  chr_v;
  logic [7:0]            chr_c;
  logic                  fin_v;
  logic                  fin_ok;
  logic [TAG_CNT_W-1:0]  fin_total;
  jsap_res_t             chr_res;
  jsap_res_t             fin_res;

  assign is_nul    = (ch_i == CH_NUL);
  assign is_ws     = ch_i inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  assign list_open = cur_i.tags < TAG_CNT_W'(MAX_TAGS);

  // Next state
  always_comb begin
    nxt_o = cur_i;
    if (is_nul) begin
      nxt_o.phase = PH_SEEK;
      nxt_o.chars = '0;
      nxt_o.tags  = '0;
    end else begin
      case (cur_i.phase)
        PH_SEEK: begin
          if (is_ws) begin
            nxt_o.phase = PH_SEEK;
          end else if (ch_i == CH_LBRACK) begin
            nxt_o.phase = PH_OUTSIDE;
          end else begin
            nxt_o.phase = PH_DONE;
          end
        end
        PH_OUTSIDE: begin
          if (ch_i == CH_RBRACK) begin
            nxt_o.phase = PH_DONE;
          end else if (ch_i == CH_QUOTE) begin
            nxt_o.chars = '0;
            nxt_o.phase = PH_INSTR;
          end
        end
        PH_INSTR: begin
          if (ch_i == CH_QUOTE) begin
            nxt_o.tags  = close_tags(cur_i.chars, cur_i.tags);
            nxt_o.chars = '0;
            nxt_o.phase = PH_OUTSIDE;
          end else if (ch_i == CH_BSLASH) begin
            nxt_o.phase = PH_ESC;
          end else begin
            nxt_o.chars = bump(cur_i.chars);
          end
        end
        PH_ESC: begin
          nxt_o.chars = bump(cur_i.chars);
          nxt_o.phase = PH_INSTR;
        end
        default: begin
          nxt_o = cur_i;
        end
      endcase
    end
  end

  // Results: an optional tag character, then an optional summary
  always_comb begin
    chr_v     = 1'b0;
    chr_c     = ch_i;
    fin_v     = 1'b0;
    fin_ok    = 1'b0;
    fin_total = '0;
    if (is_nul) begin
      case (cur_i.phase)
        PH_SEEK: begin
          fin_v = 1'b1;
        end
        PH_OUTSIDE: begin
          fin_v     = 1'b1;
          fin_ok    = 1'b1;
          fin_total = cur_i.tags;
        end
        PH_INSTR: begin
          fin_v     = 1'b1;
          fin_ok    = 1'b1;
          fin_total = close_tags(cur_i.chars, cur_i.tags);
        end
        PH_ESC: begin
          // the dangling backslash counts as a character
          chr_v     = has_room(cur_i.chars) && list_open;
          chr_c     = CH_BSLASH;
          fin_v     = 1'b1;
          fin_ok    = 1'b1;
          fin_total = close_tags(bump(cur_i.chars), cur_i.tags);
        end
        default: begin
          fin_v = 1'b0;
        end
      endcase
    end else begin
      case (cur_i.phase)
        PH_SEEK: begin
          fin_v = !is_ws && (ch_i != CH_LBRACK);
        end
        PH_OUTSIDE: begin
          fin_v     = (ch_i == CH_RBRACK);
          fin_ok    = 1'b1;
          fin_total = cur_i.tags;
        end
        PH_INSTR: begin
          chr_v = (ch_i != CH_QUOTE) && (ch_i != CH_BSLASH)
                  && has_room(cur_i.chars) && list_open;
        end
        PH_ESC: begin
          chr_v = has_room(cur_i.chars) && list_open;
        end
        default: begin
          chr_v = 1'b0;
        end
      endcase
    end

    chr_res             = '0;
    chr_res.tag_char    = chr_c;
    chr_res.tag_index   = TAG_INDEX_W'(cur_i.tags);
    chr_res.char_pos    = CHAR_POS_W'(cur_i.chars);
    chr_res.last_of_run = !fin_v;

    fin_res             = '0;
    fin_res.is_final    = 1'b1;
    fin_res.parse_ok    = fin_ok;
    fin_res.tag_total   = TAG_TOTAL_W'(fin_total);
    fin_res.last_of_run = 1'b1;

    push_o = '0;
    if (chr_v) begin
      push_o.res0 = chr_res;
      push_o.res1 = fin_res;
      push_o.cnt  = fin_v ? 2'd2 : 2'd1;
    end else begin
      push_o.res0 = fin_res;
      push_o.res1 = fin_res;
      push_o.cnt  = fin_v ? 2'd1 : 2'd0;
    end
  end

endmodule

// ===== sv/jsap_out_fifo.sv =====
// Output queue: takes up to two results per cycle, delivers one.
`include "json_string_array_parser_macros.svh"

module jsap_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jsap_pkg::jsap_push_t push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output jsap_pkg::jsap_res_t  res_o
);
  import jsap_pkg::*;

  jsap_res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   cnt_q, cnt_d;
  logic                    pop;
  logic [FIFO_PTR_W-1:0]   wr_ptr_nx;

  assign valid_o   = (cnt_q != '0);
  assign room_o    = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign res_o     = mem_q[rd_ptr_q];
  assign pop       = valid_o && ready_i;
  assign wr_ptr_nx = wr_ptr_q + FIFO_PTR_W'(1);

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + FIFO_CNT_W'(push_i.cnt) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage: first result at the write pointer, second right after it
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  `JSAP_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> cnt_q == '0, "queue not empty after reset")
  `JSAP_ASSERT(a_occ_bound, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "queue overfilled")
  `JSAP_ASSERT(a_idle_hold, (push_i.cnt == 2'd0 && !pop) |=> $stable(cnt_q),
               "occupancy moved without traffic")
  `JSAP_ASSERT(a_push_room, (push_i.cnt != 2'd0) |-> room_o, "push without room")

endmodule

// ===== sv/json_string_array_parser.sv =====
// Streaming parser for a bracketed list of quoted strings, one byte per request.
// Each accepted byte is decided in the cycle it is taken; the tag characters and
// summary it yields go into a four-entry output queue, so the block takes one
// byte every cycle while results are drained at the same pace. A byte yields at
// most two results (a zero byte after a dangling backslash); ready is low only
// while the output queue holds more than two results, i.e. when the consumer
// stalls. A zero byte ends the text and returns the parser to its start state.
`include "json_string_array_parser_macros.svh"

module json_string_array_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_final_o,
  output logic [7:0] tag_char_o,
  output logic [2:0] tag_index_o,
  output logic [3:0] char_pos_o,
  output logic       parse_ok_o,
  output logic [3:0] tag_total_o,
  output logic       last_of_run_o
);
  import jsap_pkg::*;

  jsap_state_t state_q, state_d;
  jsap_push_t  step_push;
  jsap_push_t  fifo_push;
  jsap_res_t   res;
  logic        room;
  logic        accept;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  // Per-byte decision
  jsap_step u_step (
    .cur_i  (state_q),
    .ch_i   (ch_i),
    .nxt_o  (state_d),
    .push_o (step_push)
  );

  // Only an accepted byte pushes results
  always_comb begin
    fifo_push = step_push;
    if (!accept) begin
      fifo_push.cnt = 2'd0;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= PH_SEEK;
      state_q.chars <= '0;
      state_q.tags  <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  jsap_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res)
  );

  assign is_final_o    = res.is_final;
  assign tag_char_o    = res.tag_char;
  assign tag_index_o   = res.tag_index;
  assign char_pos_o    = res.char_pos;
  assign parse_ok_o    = res.parse_ok;
  assign tag_total_o   = res.tag_total;
  assign last_of_run_o = res.last_of_run;

  `JSAP_ASSERT(a_tags_bound, state_q.tags <= TAG_CNT_W'(MAX_TAGS), "tag count past limit")
  `JSAP_ASSERT(a_chars_bound, state_q.chars <= CHAR_CNT_W'(MAX_TAG_LEN),
               "char count past limit")
  `JSAP_ASSERT(a_nul_restart, (accept && ch_i == CH_NUL) |=> (state_q.phase == PH_SEEK
               && state_q.tags == '0 && state_q.chars == '0), "zero byte did not restart")

endmodule

// ===== tb/json_string_array_parser_checker.sv =====
// Result checker for the string array parser: predicts each result and compares it.
`timescale 1ns / 100ps

module json_string_array_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        is_final_i,
  input  logic [7:0]  tag_char_i,
  input  logic [2:0]  tag_index_i,
  input  logic [3:0]  char_pos_i,
  input  logic        parse_ok_i,
  input  logic [3:0]  tag_total_i,
  input  logic        last_of_run_i,
  output int unsigned mismatches_o,
  output int unsigned awaiting_o
);
  import jsap_pkg::*;

  // Shadow parser state
  jsap_phase_e phase_q;
  int unsigned chars_seen;
  int unsigned tags_done;

  // Results still owed by the block, oldest first
  jsap_res_t parse_results_q[$];

  function automatic void clear_parser();
    phase_q    = PH_SEEK;
    chars_seen = 0;
    tags_done  = 0;
  endfunction

  // One string character; dropped once the tag or the tag list is full
  function automatic void add_tag_char(input logic [7:0] c);
    jsap_res_t r;
    r = '0;
    if (chars_seen < MAX_TAG_LEN) begin
      if (tags_done < MAX_TAGS) begin
        r.tag_char  = c;
        r.tag_index = TAG_INDEX_W'(tags_done);
        r.char_pos  = CHAR_POS_W'(chars_seen);
        parse_results_q.push_back(r);
      end
      chars_seen++;
    end
  endfunction

  function automatic void add_summary(input logic ok);
    jsap_res_t r;
    r = '0;
    r.is_final  = 1'b1;
    r.parse_ok  = ok;
    r.tag_total = TAG_TOTAL_W'(tags_done);
    parse_results_q.push_back(r);
  endfunction

  // Empty strings and strings past the list limit are not counted
  function automatic void close_tag();
    if (chars_seen > 0 && tags_done < MAX_TAGS) tags_done++;
    chars_seen = 0;
  endfunction

  // Work out the results of one accepted text byte
  function automatic void parse_byte(input logic [7:0] b);
    int unsigned n_prior;
    n_prior = parse_results_q.size();
    if (b == CH_NUL) begin
      // end of text: report the outcome if still open, then start over
      case (phase_q)
        PH_SEEK:    add_summary(1'b0);
        PH_OUTSIDE: add_summary(1'b1);
        PH_INSTR: begin
          close_tag();
          add_summary(1'b1);
        end
        PH_ESC: begin
          add_tag_char(CH_BSLASH);
          close_tag();
          add_summary(1'b1);
        end
        default: ;
      endcase
      clear_parser();
    end else begin
      case (phase_q)
        PH_SEEK: begin
          if (b == CH_LBRACK) begin
            phase_q = PH_OUTSIDE;
          end else if (b != CH_SPACE && b != CH_TAB && b != CH_LF && b != CH_CR) begin
            add_summary(1'b0);
            phase_q = PH_DONE;
          end
        end
        PH_OUTSIDE: begin
          if (b == CH_RBRACK) begin
            add_summary(1'b1);
            phase_q = PH_DONE;
          end else if (b == CH_QUOTE) begin
            chars_seen = 0;
            phase_q    = PH_INSTR;
          end
        end
        PH_INSTR: begin
          if (b == CH_QUOTE) begin
            close_tag();
            phase_q = PH_OUTSIDE;
          end else if (b == CH_BSLASH) begin
            phase_q = PH_ESC;
          end else begin
            add_tag_char(b);
          end
        end
        PH_ESC: begin
          add_tag_char(b);
          phase_q = PH_INSTR;
        end
        default: ;
      endcase
    end
    // flag the last result of this byte
    if (parse_results_q.size() > n_prior)
      parse_results_q[parse_results_q.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void cmp_field(input string name, input logic [7:0] want_v,
                                    input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches_o++;
    end
  endfunction

  function automatic void check_result();
    jsap_res_t want;
    if (parse_results_q.size() == 0) begin
      $error("unexpected result: is_final %0h tag_char %0h", is_final_i, tag_char_i);
      mismatches_o++;
    end else begin
      want = parse_results_q.pop_front();
      cmp_field("is_final", want.is_final, is_final_i);
      cmp_field("tag_char", want.tag_char, tag_char_i);
      cmp_field("tag_index", want.tag_index, tag_index_i);
      cmp_field("char_pos", want.char_pos, char_pos_i);
      cmp_field("parse_ok", want.parse_ok, parse_ok_i);
      cmp_field("tag_total", want.tag_total, tag_total_i);
      cmp_field("last_of_run", want.last_of_run, last_of_run_i);
    end
  endfunction

  // Requests are predicted before results are checked, so a same-cycle path is covered
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      parse_results_q.delete();
      mismatches_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) parse_byte(ch_i);
      if (out_valid_i && out_ready_i) check_result();
    end
    awaiting_o = parse_results_q.size();
  end

endmodule

// ===== tb/tb_json_string_array_parser.sv =====
// Testbench top for the string array parser: text stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_json_string_array_parser;
  import jsap_pkg::*;

  localparam int unsigned ITEM_TARGET  = 650;
  localparam int unsigned QUIET_TAIL   = 60;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] ch_i        = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       is_final_o;
  logic [7:0] tag_char_o;
  logic [2:0] tag_index_o;
  logic [3:0] char_pos_o;
  logic       parse_ok_o;
  logic [3:0] tag_total_o;
  logic       last_of_run_o;

  int unsigned mismatches;
  int unsigned awaiting;

  bit          quiet    = 1'b0;  // no idling on either side
  bit          hold_req = 1'b0;  // ask the receiver for a long hold-off
  bit          holding  = 1'b0;
  bit          held     = 1'b0;
  int unsigned gap_pct;
  int unsigned bytes_sent = 0;
  logic [7:0]  text_q[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  json_string_array_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_final_o    (is_final_o),
    .tag_char_o    (tag_char_o),
    .tag_index_o   (tag_index_o),
    .char_pos_o    (char_pos_o),
    .parse_ok_o    (parse_ok_o),
    .tag_total_o   (tag_total_o),
    .last_of_run_o (last_of_run_o)
  );

  json_string_array_parser_checker results_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .ch_i          (ch_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_final_i    (is_final_o),
    .tag_char_i    (tag_char_o),
    .tag_index_i   (tag_index_o),
    .char_pos_i    (char_pos_o),
    .parse_ok_i    (parse_ok_o),
    .tag_total_i   (tag_total_o),
    .last_of_run_i (last_of_run_o),
    .mismatches_o  (mismatches),
    .awaiting_o    (awaiting)
  );

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // String character that needs no escape
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  // Junk between strings; must not open a string or close the array
  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_RBRACK);
    return c;
  endfunction

  // Mostly short strings, now and then past the tag length limit
  function automatic int unsigned pick_len();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
  endfunction

  task automatic add_content(input int unsigned len);
    logic [7:0] esc;
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       esc = CH_QUOTE;
          1:       esc = CH_BSLASH;
          default: esc = 8'($urandom_range(1, 255));
        endcase
        text_q.push_back(CH_BSLASH);
        text_q.push_back(esc);
      end else begin
        text_q.push_back(plain_char());
      end
    end
  endtask

  // One text ending in a zero byte: mostly arrays, some noise and broken openings
  task automatic build_text();
    int unsigned kind;
    int unsigned n_str;
    logic [7:0]  b;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(1, 255)));
    end else if (kind == 1) begin
      do b = 8'($urandom_range(1, 255));
      while (b == CH_LBRACK || b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR);
      text_q.push_back(b);
      repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) text_q.push_back(blank_byte());
      text_q.push_back(CH_LBRACK);
      n_str = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 4);
      repeat (n_str) begin
        repeat ($urandom_range(0, 2)) text_q.push_back(filler_byte());
        text_q.push_back(CH_QUOTE);
        add_content(pick_len());
        text_q.push_back(CH_QUOTE);
      end
      repeat ($urandom_range(0, 1)) text_q.push_back(filler_byte());
      case ($urandom_range(0, 9))
        // text cut off inside a string
        0: begin
          text_q.push_back(CH_QUOTE);
          add_content(pick_len());
        end
        // cut off right after a backslash
        1: begin
          text_q.push_back(CH_QUOTE);
          add_content(pick_len());
          text_q.push_back(CH_BSLASH);
        end
        // cut off between strings
        2: ;
        default: begin
          text_q.push_back(CH_RBRACK);
          repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(1, 255)));
        end
      endcase
    end
    text_q.push_back(CH_NUL);
  endtask

  // Offer one request and hold it until taken; may idle first
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_text();
    gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
    foreach (text_q[i]) send_byte(text_q[i]);
    bytes_sent += text_q.size();
    text_q.delete();
  endtask

  // Stop offering until every owed result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (awaiting == 0);
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, ready stretches, one long hold-off on request
  initial begin : receiver
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holding  = 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) < 3) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty text, blanks and escaped quote, junk after close,
    // bad opening, backslash pending at end, empty string with end outside
    text_q = {CH_NUL,
              CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_LBRACK, CH_QUOTE, 8'h61, CH_BSLASH,
              CH_QUOTE, CH_QUOTE, CH_RBRACK, 8'h71, CH_NUL,
              8'h5A, CH_NUL,
              CH_LBRACK, CH_QUOTE, 8'hFF, CH_BSLASH, CH_NUL,
              CH_LBRACK, CH_QUOTE, CH_QUOTE, 8'h01, CH_NUL};
    send_text();
    drain_results();

    // Random texts, with one long receiver hold-off midway
    while (bytes_sent < ITEM_TARGET - QUIET_TAIL) begin
      if (!held && bytes_sent >= ITEM_TARGET / 2) begin
        held = 1'b1;
        in_valid_i <= 1'b0;
        hold_req = 1'b1;
        @(posedge clk_i);
        wait (holding);
        // enough characters to fill the output queue during the hold
        text_q.push_back(CH_LBRACK);
        text_q.push_back(CH_QUOTE);
        repeat (14) text_q.push_back(plain_char());
        text_q.push_back(CH_QUOTE);
        text_q.push_back(CH_RBRACK);
        text_q.push_back(CH_NUL);
      end else begin
        build_text();
      end
      send_text();
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    // Tail at full rate on both sides
    quiet = 1'b1;
    while (bytes_sent < ITEM_TARGET) begin
      build_text();
      send_text();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaiting == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
